@@ rtl/cvcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvcs_pkg
// Shared types, constants and helpers for the cloth constraint step block.
// ----------------------------------------------------------------------------
package cvcs_pkg;

   localparam int MAX_GRID          = 31;
   localparam int SOLVER_ITERATIONS = 3;
   localparam int GRID_W            = $clog2(MAX_GRID + 1);
   localparam int ADDR_W            = 2 * GRID_W;
   localparam int DEPTH             = 1 << ADDR_W;
   localparam int ITER_W            = $clog2(SOLVER_ITERATIONS + 1);

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_STEP = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [2:0] CSR_GRAVITY_Y  = 3'd0;
   localparam logic [2:0] CSR_REST_HORIZ = 3'd1;
   localparam logic [2:0] CSR_REST_VERT  = 3'd2;
   localparam logic [2:0] CSR_BOX_MARGIN = 3'd3;
   localparam logic [2:0] CSR_GRID_COLS  = 3'd4;
   localparam logic [2:0] CSR_GRID_ROWS  = 3'd5;

   localparam logic signed [16:0] GRAVITY_RESET = -17'sd89;
   localparam logic [30:0] REST_H_RESET = 31'd72090;
   localparam logic [30:0] REST_V_RESET = 31'd65536;
   localparam logic [30:0] MARGIN_RESET = 31'd65536;
   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(MAX_GRID);

   typedef struct packed {
      logic [1:0]         req_type;
      logic [4:0]         vert_col;
      logic [4:0]         vert_row;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic               in_pinned;
   } cvcs_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
   } cvcs_rsp_type;

   typedef enum logic {
      UOP_SQRT,
      UOP_DIV
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } unit_sts_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_V_RD,
      ST_V_CALC,
      ST_R_RDA,
      ST_R_RDB,
      ST_R_DIFF,
      ST_R_SQ,
      ST_R_SQRT_GO,
      ST_R_SQRT_WAIT,
      ST_R_CHK,
      ST_R_MUL,
      ST_R_DIV_GO,
      ST_R_DIV_WAIT,
      ST_R_WRA,
      ST_R_WRB,
      ST_B_RD,
      ST_B_ACC,
      ST_B_OUT
   } state_type;

   // Saturate a widened signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/cvcs_iter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvcs_iter_unit
// Shared bit-serial unit: 64-bit integer square root or 64/33 division with a
// 32-bit quotient, one result bit per cycle.
// ----------------------------------------------------------------------------
module cvcs_iter_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  cvcs_pkg::unit_ctl_type ctl,
   input  wire [63:0]            operand_n,
   input  wire [32:0]            operand_d,
   output cvcs_pkg::unit_sts_type sts
);
   import cvcs_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   unit_op_type op_ff;
   logic [4:0]  cnt_ff;
   logic [35:0] rem_ff, rem_in;
   logic [63:0] sh_ff, sh_in;
   logic [31:0] root_ff, root_in;
   logic [32:0] den_ff;
   logic [35:0] rem_sh, trial;
   logic        geq;

   always_comb begin
      if (op_ff == UOP_SQRT) begin
         rem_sh = {rem_ff[33:0], sh_ff[63:62]};
         trial  = {2'b00, root_ff, 2'b01};
         sh_in  = {sh_ff[61:0], 2'b00};
      end else begin
         rem_sh = {rem_ff[34:0], sh_ff[63]};
         trial  = {3'b000, den_ff};
         sh_in  = {sh_ff[62:0], 1'b0};
      end
      geq     = rem_sh >= trial;
      rem_in  = geq ? rem_sh - trial : rem_sh;
      root_in = {root_ff[30:0], geq};
      busy_in = busy_ff && (cnt_ff != 5'd0);
      done_in = busy_ff && (cnt_ff == 5'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      if (ctl.start) begin
         op_ff   <= ctl.op;
         cnt_ff  <= 5'd31;
         root_ff <= 32'd0;
         den_ff  <= operand_d;
         if (ctl.op == UOP_SQRT) begin
            rem_ff <= 36'd0;
            sh_ff  <= operand_n;
         end else begin
            rem_ff <= {4'd0, operand_n[63:32]};
            sh_ff  <= {operand_n[31:0], 32'd0};
         end
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 5'd1;
         rem_ff  <= rem_in;
         sh_ff   <= sh_in;
         root_ff <= root_in;
      end
   end

   assign sts.done   = done_ff;
   assign sts.result = root_ff;

endmodule
`default_nettype wire

@@ rtl/cloth_verlet_constraint_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cloth_verlet_constraint_step
// Cloth grid solver: Verlet integration, stretch-only distance constraints
// relaxed Gauss-Seidel, and a widened bounding box, in Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   -----------------------------
//  request   start, busy            req_data  (cvcs_req_type)
//  result    rsp_valid (strobe)     rsp_data  (cvcs_rsp_type)
//  config    csr_valid, csr_ready   csr_index, csr_wdata
//
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for a single cycle with rsp_valid.
// Load and unknown requests answer in the cycle after acceptance; a read passes through ST_READ first.
// A step integrates every active vertex, relaxes each constraint in each of the
// three sweeps (a square root and, for a constraint that is not skipped, three
// divisions in the shared iterative unit), and then scans the vertices for the
// bounding box.
// After reset the pinned flags are cleared one entry per cycle, all 1024 of them,
// with busy high meanwhile; configuration writes are taken throughout.
// The receiver cannot stall results, so the block never waits on it.
//
module cloth_verlet_constraint_step (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  cvcs_pkg::cvcs_req_type req_data,
   output logic                   rsp_valid,
   output cvcs_pkg::cvcs_rsp_type rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [2:0]              csr_index,
   input  wire [31:0]             csr_wdata
);
   import cvcs_pkg::*;

   // Configuration registers.
   logic signed [16:0] gravity_ff;
   logic [30:0]        rest_h_ff, rest_v_ff, margin_ff;
   logic [GRID_W-1:0]  cols_ff, rows_ff;
   logic [GRID_W-1:0]  cols_eff, rows_eff;

   // Vertex memories; position stores are only meaningful once loaded.
   logic [31:0] cur_x_mem  [DEPTH];
   logic [31:0] cur_y_mem  [DEPTH];
   logic [31:0] cur_z_mem  [DEPTH];
   logic [31:0] prev_x_mem [DEPTH];
   logic [31:0] prev_y_mem [DEPTH];
   logic [31:0] prev_z_mem [DEPTH];
   logic        pin_mem    [DEPTH];

   logic signed [31:0] rd_cur_ff  [3];
   logic signed [31:0] rd_prev_ff [3];
   logic               rd_pin_ff;

   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic               cur_we, prev_we, pin_we, pin_wdata;
   logic signed [31:0] cur_wdata  [3];
   logic signed [31:0] prev_wdata [3];

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff;

   // Loop counters: column, row, sweep direction, solver pass and axis.
   logic [GRID_W-1:0] c_ff, r_ff;
   logic              vert_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [1:0]        k_ff;

   // Per-constraint working registers.
   logic signed [31:0] a_pos_ff [3];
   logic signed [31:0] b_pos_ff [3];
   logic               d_neg_ff [3];
   logic [31:0]        mag_ff   [3];
   logic               pa_ff, pb_ff;
   logic [63:0]        sum_ff, prod_ff;
   logic [31:0]        len_ff, e_ff;
   logic [32:0]        den_ff;
   logic               first_ff;
   logic signed [31:0] mn_ff [3];
   logic signed [31:0] mx_ff [3];

   logic               rsp_valid_ff, rsp_valid_in;
   cvcs_rsp_type       rsp_ff, rsp_in;

   unit_ctl_type       unit_ctl;
   unit_sts_type       unit_sts;
   logic [63:0]        unit_n;

   logic               accept;
   logic [ADDR_W-1:0]  req_addr, grid_addr, a_addr, b_addr;
   logic               grid_last, con_last_h, con_last_v, all_last;
   logic [30:0]        rest_sel;
   logic signed [31:0] v_new [3];
   logic [31:0]        mul_a, mul_b;
   logic signed [34:0] corr;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cols_eff  = (cols_ff == '0) ? GRID_W'(1) : cols_ff;
   assign rows_eff  = (rows_ff == '0) ? GRID_W'(1) : rows_ff;
   assign req_addr  = {req_data.vert_row, req_data.vert_col};
   assign grid_addr = {r_ff, c_ff};
   assign a_addr    = {r_ff, c_ff};
   assign b_addr    = vert_ff ? {r_ff + GRID_W'(1), c_ff} : {r_ff, c_ff + GRID_W'(1)};
   assign grid_last = (c_ff == cols_eff) && (r_ff == rows_eff);
   assign rest_sel  = vert_ff ? rest_v_ff : rest_h_ff;

   // Last horizontal constraint of a sweep, last vertical one, last of a step.
   assign con_last_h = !vert_ff && (r_ff == rows_eff) && (c_ff == cols_eff - GRID_W'(1));
   assign con_last_v = vert_ff && (r_ff == rows_eff - GRID_W'(1)) && (c_ff == cols_eff);
   assign all_last   = con_last_v && (iter_ff == ITER_W'(SOLVER_ITERATIONS - 1));

   // Verlet update of one vertex; gravity acts on y only.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v_new[k] = sat32((35'(rd_cur_ff[k]) <<< 1) - 35'(rd_prev_ff[k])
                          + ((k == 1) ? 35'(gravity_ff) : 35'sd0));
      end
   end

   // The one multiplier: squares for the length, then |d|*e per axis.
   assign mul_a = mag_ff[k_ff];
   assign mul_b = (state_ff == ST_R_MUL) ? e_ff : mag_ff[k_ff];
   assign corr  = d_neg_ff[k_ff] ? -35'(unit_sts.result) : 35'(unit_sts.result);

   assign unit_n = (state_ff == ST_R_SQRT_GO) ? sum_ff
                                              : prod_ff + 64'(den_ff[32:1]);

   cvcs_iter_unit u_iter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (unit_ctl),
      .operand_n (unit_n),
      .operand_d (den_ff),
      .sts       (unit_sts)
   );

   // Memory port control.
   always_comb begin
      rd_addr   = grid_addr;
      wr_addr   = grid_addr;
      cur_we    = 1'b0;
      prev_we   = 1'b0;
      pin_we    = 1'b0;
      pin_wdata = 1'b0;
      for (int k = 0; k < 3; k++) begin
         cur_wdata[k]  = v_new[k];
         prev_wdata[k] = rd_cur_ff[k];
      end
      case (state_ff)
         ST_CLEAR: begin
            wr_addr = clr_ff;
            pin_we  = 1'b1;
         end
         ST_IDLE: begin
            rd_addr = req_addr;
            wr_addr = req_addr;
            if (accept && req_data.req_type == REQ_LOAD) begin
               cur_we    = 1'b1;
               prev_we   = 1'b1;
               pin_we    = 1'b1;
               pin_wdata = req_data.in_pinned;
            end
            cur_wdata[0]  = req_data.in_x;
            cur_wdata[1]  = req_data.in_y;
            cur_wdata[2]  = req_data.in_z;
            prev_wdata[0] = req_data.in_x;
            prev_wdata[1] = req_data.in_y;
            prev_wdata[2] = req_data.in_z;
         end
         ST_V_CALC: begin
            cur_we  = !rd_pin_ff;
            prev_we = !rd_pin_ff;
         end
         ST_R_RDA: rd_addr = a_addr;
         ST_R_RDB: rd_addr = b_addr;
         ST_R_WRA: begin
            wr_addr = a_addr;
            cur_we  = !pa_ff;
            for (int k = 0; k < 3; k++) cur_wdata[k] = a_pos_ff[k];
         end
         ST_R_WRB: begin
            wr_addr = b_addr;
            cur_we  = !pb_ff;
            for (int k = 0; k < 3; k++) cur_wdata[k] = b_pos_ff[k];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_x_mem[wr_addr] <= cur_wdata[0];
         cur_y_mem[wr_addr] <= cur_wdata[1];
         cur_z_mem[wr_addr] <= cur_wdata[2];
      end
      if (prev_we) begin
         prev_x_mem[wr_addr] <= prev_wdata[0];
         prev_y_mem[wr_addr] <= prev_wdata[1];
         prev_z_mem[wr_addr] <= prev_wdata[2];
      end
      if (pin_we) begin
         pin_mem[wr_addr] <= pin_wdata;
      end
      rd_cur_ff[0]  <= cur_x_mem[rd_addr];
      rd_cur_ff[1]  <= cur_y_mem[rd_addr];
      rd_cur_ff[2]  <= cur_z_mem[rd_addr];
      rd_prev_ff[0] <= prev_x_mem[rd_addr];
      rd_prev_ff[1] <= prev_y_mem[rd_addr];
      rd_prev_ff[2] <= prev_z_mem[rd_addr];
      rd_pin_ff     <= pin_mem[rd_addr];
   end

   // Sequencer: next state, unit control and result.
   always_comb begin
      state_in       = state_ff;
      unit_ctl.start = 1'b0;
      unit_ctl.op    = UOP_SQRT;
      rsp_valid_in   = 1'b0;
      rsp_in         = '0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_STEP: state_in = ST_V_RD;
                  REQ_READ: state_in = ST_READ;
                  default:  rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in.out_x = rd_cur_ff[0];
            rsp_in.out_y = rd_cur_ff[1];
            rsp_in.out_z = rd_cur_ff[2];
            state_in     = ST_IDLE;
         end
         ST_V_RD:   state_in = ST_V_CALC;
         ST_V_CALC: state_in = grid_last ? ST_R_RDA : ST_V_RD;
         ST_R_RDA:  state_in = ST_R_RDB;
         ST_R_RDB:  state_in = ST_R_DIFF;
         ST_R_DIFF: state_in = ST_R_SQ;
         ST_R_SQ: begin
            if (k_ff == 2'd3) state_in = ST_R_SQRT_GO;
         end
         ST_R_SQRT_GO: begin
            unit_ctl.start = 1'b1;
            state_in       = ST_R_SQRT_WAIT;
         end
         ST_R_SQRT_WAIT: begin
            if (unit_sts.done) state_in = ST_R_CHK;
         end
         ST_R_CHK: begin
            // Short, degenerate or fully pinned constraints are left alone.
            if (len_ff < 32'(rest_sel) || len_ff == 32'd0 || (pa_ff && pb_ff)) begin
               state_in = all_last ? ST_B_RD : ST_R_RDA;
            end else begin
               state_in = ST_R_MUL;
            end
         end
         ST_R_MUL: state_in = ST_R_DIV_GO;
         ST_R_DIV_GO: begin
            unit_ctl.start = 1'b1;
            unit_ctl.op    = UOP_DIV;
            state_in       = ST_R_DIV_WAIT;
         end
         ST_R_DIV_WAIT: begin
            unit_ctl.op = UOP_DIV;
            if (unit_sts.done) state_in = (k_ff == 2'd2) ? ST_R_WRA : ST_R_MUL;
         end
         ST_R_WRA: state_in = ST_R_WRB;
         ST_R_WRB: state_in = all_last ? ST_B_RD : ST_R_RDA;
         ST_B_RD:  state_in = ST_B_ACC;
         ST_B_ACC: state_in = grid_last ? ST_B_OUT : ST_B_RD;
         ST_B_OUT: begin
            rsp_valid_in     = 1'b1;
            rsp_in.box_min_x = sat32(35'(mn_ff[0]) - 35'(margin_ff));
            rsp_in.box_min_y = sat32(35'(mn_ff[1]) - 35'(margin_ff));
            rsp_in.box_min_z = sat32(35'(mn_ff[2]) - 35'(margin_ff));
            rsp_in.box_max_x = sat32(35'(mx_ff[0]) + 35'(margin_ff));
            rsp_in.box_max_y = sat32(35'(mx_ff[1]) + 35'(margin_ff));
            rsp_in.box_max_z = sat32(35'(mx_ff[2]) + 35'(margin_ff));
            state_in         = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gravity_ff   <= GRAVITY_RESET;
         rest_h_ff    <= REST_H_RESET;
         rest_v_ff    <= REST_V_RESET;
         margin_ff    <= MARGIN_RESET;
         cols_ff      <= GRID_RESET;
         rows_ff      <= GRID_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + ADDR_W'(1);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRAVITY_Y:  gravity_ff <= csr_wdata[16:0];
               CSR_REST_HORIZ: rest_h_ff  <= csr_wdata[30:0];
               CSR_REST_VERT:  rest_v_ff  <= csr_wdata[30:0];
               CSR_BOX_MARGIN: margin_ff  <= csr_wdata[30:0];
               CSR_GRID_COLS:  cols_ff    <= csr_wdata[GRID_W-1:0];
               CSR_GRID_ROWS:  rows_ff    <= csr_wdata[GRID_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (rsp_valid_in) rsp_ff <= rsp_in;
      case (state_ff)
         ST_IDLE: begin
            c_ff     <= '0;
            r_ff     <= '0;
            vert_ff  <= 1'b0;
            iter_ff  <= '0;
            first_ff <= 1'b1;
         end
         ST_V_CALC, ST_B_ACC: begin
            if (state_ff == ST_B_ACC) begin
               for (int k = 0; k < 3; k++) begin
                  if (first_ff || rd_cur_ff[k] < mn_ff[k]) mn_ff[k] <= rd_cur_ff[k];
                  if (first_ff || rd_cur_ff[k] > mx_ff[k]) mx_ff[k] <= rd_cur_ff[k];
               end
               first_ff <= 1'b0;
            end
            if (c_ff == cols_eff) begin
               c_ff <= '0;
               r_ff <= grid_last ? '0 : r_ff + GRID_W'(1);
            end else begin
               c_ff <= c_ff + GRID_W'(1);
            end
         end
         ST_R_RDB: begin
            pa_ff <= rd_pin_ff;
            for (int k = 0; k < 3; k++) a_pos_ff[k] <= rd_cur_ff[k];
         end
         ST_R_DIFF: begin
            pb_ff  <= rd_pin_ff;
            sum_ff <= '0;
            k_ff   <= 2'd0;
            for (int k = 0; k < 3; k++) begin
               logic signed [31:0] dif;
               dif = sat32(35'(a_pos_ff[k]) - 35'(rd_cur_ff[k]));
               b_pos_ff[k] <= rd_cur_ff[k];
               d_neg_ff[k] <= dif[31];
               mag_ff[k]   <= dif[31] ? 32'(-33'(dif)) : 32'(dif);
            end
         end
         ST_R_SQ: begin
            prod_ff <= 64'(mul_a) * 64'(mul_b);
            if (k_ff != 2'd0) sum_ff <= sum_ff + prod_ff;
            k_ff <= k_ff + 2'd1;
         end
         ST_R_SQRT_WAIT: begin
            if (unit_sts.done) len_ff <= unit_sts.result;
         end
         ST_R_CHK: begin
            e_ff   <= len_ff - 32'(rest_sel);
            den_ff <= (pa_ff || pb_ff) ? {1'b0, len_ff} : {len_ff, 1'b0};
            k_ff   <= 2'd0;
         end
         ST_R_MUL: prod_ff <= 64'(mul_a) * 64'(mul_b);
         ST_R_DIV_WAIT: begin
            if (unit_sts.done) begin
               a_pos_ff[k_ff] <= sat32(35'(a_pos_ff[k_ff]) - corr);
               b_pos_ff[k_ff] <= sat32(35'(b_pos_ff[k_ff]) + corr);
               k_ff           <= k_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
      // Constraint walk: horizontal then vertical, column outer, row inner.
      if ((state_ff == ST_V_CALC && grid_last) ||
          (state_ff == ST_R_CHK && state_in != ST_R_MUL) ||
          state_ff == ST_R_WRB) begin
         if (state_ff == ST_V_CALC || all_last) begin
            c_ff    <= '0;
            r_ff    <= '0;
            vert_ff <= 1'b0;
            iter_ff <= '0;
         end else if (con_last_h) begin
            c_ff    <= '0;
            r_ff    <= '0;
            vert_ff <= 1'b1;
         end else if (con_last_v) begin
            c_ff    <= '0;
            r_ff    <= '0;
            vert_ff <= 1'b0;
            iter_ff <= iter_ff + ITER_W'(1);
         end else if ((!vert_ff && r_ff == rows_eff) ||
                      (vert_ff && r_ff == rows_eff - GRID_W'(1))) begin
            r_ff <= '0;
            c_ff <= c_ff + GRID_W'(1);
         end else begin
            r_ff <= r_ff + GRID_W'(1);
         end
      end
   end

endmodule
`default_nettype wire
